// ===== hw/rtl/rvx_pkg.sv =====
package rvx_pkg;

	// data memory size in bytes and its address width
	localparam int unsigned MEM_BYTES = 65536;
	localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);

	// major opcodes
	localparam logic [6:0] OP_R     = 7'h33;
	localparam logic [6:0] OP_LOAD  = 7'h03;
	localparam logic [6:0] OP_I     = 7'h13;
	localparam logic [6:0] OP_SYS   = 7'h73;
	localparam logic [6:0] OP_STORE = 7'h23;
	localparam logic [6:0] OP_BR    = 7'h63;
	localparam logic [6:0] OP_LUI   = 7'h37;
	localparam logic [6:0] OP_JAL   = 7'h6f;

	localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
	localparam logic [31:0] LUI_MASK   = 32'hffff_f000;
	localparam logic [31:0] A0_PRINT   = 32'd1;
	localparam logic [31:0] A0_EXIT    = 32'd10;
	localparam logic [4:0]  REG_A0     = 5'd10;
	localparam logic [4:0]  REG_A1     = 5'd11;

	// funct7 groups
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [6:0] F7_MULD = 7'h01;

	// funct3 codes
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;
	localparam logic [2:0] F3_MUL  = 3'd0;
	localparam logic [2:0] F3_MULH = 3'd1;
	localparam logic [2:0] F3_DIV  = 3'd4;
	localparam logic [2:0] F3_REM  = 3'd6;
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_WORD = 3'd2;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_INSTR = 3'd1;
	localparam logic [2:0] ST_BAD_READ  = 3'd2;
	localparam logic [2:0] ST_BAD_WRITE = 3'd3;
	localparam logic [2:0] ST_PRINT     = 3'd4;
	localparam logic [2:0] ST_EXIT      = 3'd5;
	localparam logic [2:0] ST_BAD_ECALL = 3'd6;
	localparam logic [2:0] ST_HALTED    = 3'd7;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_MUL,
		S_DIV,
		S_DIVF,
		S_LOAD,
		S_STORE,
		S_RESP
	} state_t;

	typedef enum logic [2:0] {
		K_ALU,
		K_MUL,
		K_DIV,
		K_LOAD,
		K_STORE
	} kind_t;

endpackage

// ===== hw/rtl/rvx_if.sv =====
interface rvx_instr_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;
	modport source (output valid, output instr_word, input ready);
	modport sink (input valid, input instr_word, output ready);
endinterface

interface rvx_result_if;
	logic               valid;
	logic               ready;
	logic        [31:0] next_pc;
	logic        [2:0]  status;
	logic signed [31:0] print_value;
	modport source (output valid, output next_pc, output status, output print_value,
		input ready);
	modport sink (input valid, input next_pc, input status, input print_value,
		output ready);
endinterface

// ===== hw/rtl/rv32_subset_instruction_executor.sv =====
// RV32 subset executor: one instruction word in, one result item out.
// instr_ch carries the instruction executed at the current PC; result_ch
// returns the next PC, a status code and the print value. An item moves
// when valid and ready are both high.
// cfg_we/cfg_wdata set the PC; write only while no item is in flight.
// Steps per item, from accept to result valid:
//   ALU, branch, jal, lui, ecall: execute, then result
//   mul/mulh: execute, multiply, result; div/rem: execute, one quotient bit per cycle, sign fix, result
//   loads and stores: execute, then len bytes, len = 1, 2 or 4,
//   one byte per cycle through the single-port byte memory, then result.
// A new item is accepted once the previous one has left the execute path;
// the result register holds a stalled result and the next item can be
// accepted meanwhile, but its result waits until the register is free.
// After reset the data memory is swept to zero, one byte per cycle, over
// all MEM_BYTES (65536) bytes; no item is accepted during the sweep. Reset
// clears the register file, the halt flag, and sets the PC to zero.
// An error or exit halts the block: later items return status halted.
module rv32_subset_instruction_executor
	import rvx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	rvx_instr_if.sink   instr_ch,
	rvx_result_if.source result_ch
);

	state_t state_q, state_d;

	// architectural state
	logic [31:0] pc_q;
	logic        halted_q;
	logic [31:0] rf [32];
	logic [31:0] rf_vld_q;
	logic [7:0]  dmem [MEM_BYTES];

	// instruction and operands
	logic [31:0] ir_q;
	logic [31:0] a_raw_q, b_raw_q;
	logic        a_vld_q, b_vld_q;
	logic [31:0] a, b;

	// multi-cycle units
	logic [65:0] prod_q;
	logic [31:0] dq_q, dd_q;
	logic [32:0] dr_q;
	logic [4:0]  dcnt_q;
	logic [MEM_AW-1:0] addr_q, clr_q;
	logic [2:0]  cnt_q, len_q;
	logic [31:0] ld_q;
	logic [7:0]  dm_rd_q;

	// result staging and output register
	logic [31:0] res_npc_q, res_pv_q;
	logic [2:0]  res_st_q;
	logic        ovalid_q;
	logic [31:0] onpc_q, opv_q;
	logic [2:0]  ost_q;

	logic accept;
	assign instr_ch.ready = (state_q == S_IDLE);
	assign accept = instr_ch.valid && instr_ch.ready;

	assign result_ch.valid       = ovalid_q;
	assign result_ch.next_pc     = onpc_q;
	assign result_ch.status      = ost_q;
	assign result_ch.print_value = opv_q;

	logic out_free;
	assign out_free = !ovalid_q || result_ch.ready;

	assign a = a_vld_q ? a_raw_q : '0;
	assign b = b_vld_q ? b_raw_q : '0;

	// instruction fields
	logic [6:0]  op, f7;
	logic [2:0]  f3;
	logic [4:0]  rd;
	logic [31:0] imm_i, imm_s, imm_b, imm_j;
	assign op = ir_q[6:0];
	assign f3 = ir_q[14:12];
	assign f7 = ir_q[31:25];
	assign rd = ir_q[11:7];
	assign imm_i = {{20{ir_q[31]}}, ir_q[31:20]};
	assign imm_s = {{20{ir_q[31]}}, ir_q[31:25], ir_q[11:7]};
	assign imm_b = {{19{ir_q[31]}}, ir_q[31], ir_q[7], ir_q[30:25], ir_q[11:8], 1'b0};
	assign imm_j = {{11{ir_q[31]}}, ir_q[31], ir_q[19:12], ir_q[20], ir_q[30:21], 1'b0};

	// decode and execute
	kind_t       kind_e;
	logic [2:0]  st_e;
	logic        wb_en_e;
	logic [31:0] wb_e, npc_e, pv_e, addr_e, opb, alu_r;
	logic [2:0]  len_e;
	logic [32:0] end_e;
	logic        alu_ok;

	// shared ALU for register and immediate forms
	always_comb begin
		opb = (op == OP_I) ? imm_i : b;
		alu_ok = 1'b1;
		alu_r = '0;
		unique case (f3)
			F3_ADD: alu_r = (op == OP_R && f7 == F7_ALT) ? a - opb : a + opb;
			F3_SLL: alu_r = a << opb[4:0];
			F3_SLT: alu_r = {31'd0, $signed(a) < $signed(opb)};
			F3_XOR: alu_r = a ^ opb;
			F3_SR:  alu_r = f7[5] ? 32'($signed(a) >>> opb[4:0]) : a >> opb[4:0];
			F3_OR:  alu_r = a | opb;
			F3_AND: alu_r = a & opb;
			default: alu_ok = 1'b0;
		endcase
	end

	always_comb begin
		kind_e  = K_ALU;
		st_e    = ST_OK;
		wb_en_e = 1'b0;
		wb_e    = alu_r;
		npc_e   = pc_q + 32'd4;
		pv_e    = '0;
		len_e   = 3'd1 << f3[1:0];
		addr_e  = a + ((op == OP_STORE) ? imm_s : imm_i);
		end_e   = {1'b0, addr_e} + {30'd0, len_e};
		unique case (op)
			OP_R: begin
				if (f7 == F7_BASE) begin
					wb_en_e = alu_ok;
					if (!alu_ok) st_e = ST_BAD_INSTR;
				end else if (f7 == F7_ALT) begin
					wb_en_e = (f3 == F3_ADD) || (f3 == F3_SR);
					if (!wb_en_e) st_e = ST_BAD_INSTR;
				end else if (f7 == F7_MULD) begin
					priority if (f3 == F3_MUL || f3 == F3_MULH) begin
						kind_e = K_MUL;
					end else if (f3 == F3_DIV || f3 == F3_REM) begin
						if (b == '0) begin
							wb_en_e = 1'b1;
							wb_e = (f3 == F3_DIV) ? '1 : a;
						end else begin
							kind_e = K_DIV;
						end
					end else begin
						st_e = ST_BAD_INSTR;
					end
				end else begin
					st_e = ST_BAD_INSTR;
				end
			end
			OP_I: begin
				wb_en_e = alu_ok;
				if (!alu_ok) st_e = ST_BAD_INSTR;
				if (f3 == F3_SLL && f7 != F7_BASE) st_e = ST_BAD_INSTR;
				if (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT) st_e = ST_BAD_INSTR;
			end
			OP_LOAD: begin
				priority if (f3 > F3_WORD) st_e = ST_BAD_INSTR;
				else if (end_e > 33'(MEM_BYTES)) st_e = ST_BAD_READ;
				else kind_e = K_LOAD;
			end
			OP_STORE: begin
				priority if (f3 > F3_WORD) st_e = ST_BAD_INSTR;
				else if (end_e > 33'(MEM_BYTES)) st_e = ST_BAD_WRITE;
				else kind_e = K_STORE;
			end
			OP_SYS: begin
				// a holds a0 and b holds a1 for this opcode
				priority if (ir_q != ECALL_WORD) st_e = ST_BAD_INSTR;
				else if (a == A0_PRINT) begin
					st_e = ST_PRINT;
					pv_e = b;
				end else if (a == A0_EXIT) st_e = ST_EXIT;
				else st_e = ST_BAD_ECALL;
			end
			OP_BR: begin
				priority if (f3 == F3_BEQ) begin
					if (a == b) npc_e = pc_q + imm_b;
				end else if (f3 == F3_BNE) begin
					if (a != b) npc_e = pc_q + imm_b;
				end else st_e = ST_BAD_INSTR;
			end
			OP_LUI: begin
				wb_en_e = 1'b1;
				wb_e = ir_q & LUI_MASK;
			end
			OP_JAL: begin
				wb_en_e = 1'b1;
				wb_e = pc_q + 32'd4;
				npc_e = pc_q + imm_j;
			end
			default: st_e = ST_BAD_INSTR;
		endcase
		// errors and exit leave state alone
		if (st_e != ST_OK && st_e != ST_PRINT) begin
			kind_e  = K_ALU;
			wb_en_e = 1'b0;
			npc_e   = pc_q;
			pv_e    = '0;
		end
	end

	// divider step and sign fix
	logic [32:0] dr_sh, dr_sub;
	logic [31:0] q_fix, r_fix;
	assign dr_sh  = {dr_q[31:0], dq_q[31]};
	assign dr_sub = dr_sh - {1'b0, dd_q};
	assign q_fix  = (a[31] ^ b[31]) ? -dq_q : dq_q;
	assign r_fix  = a[31] ? -dr_q[31:0] : dr_q[31:0];

	// load byte assembly
	logic [1:0]  ld_idx;
	logic [31:0] ld_cur, ld_ext;
	assign ld_idx = 2'(cnt_q - 3'd1);
	always_comb begin
		ld_cur = ld_q;
		ld_cur[8*ld_idx +: 8] = dm_rd_q;
		unique case (len_q)
			3'd1:    ld_ext = {{24{ld_cur[7]}}, ld_cur[7:0]};
			3'd2:    ld_ext = {{16{ld_cur[15]}}, ld_cur[15:0]};
			default: ld_ext = ld_cur;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
			S_IDLE:  if (accept) state_d = halted_q ? S_RESP : S_EXEC;
			S_EXEC: begin
				unique case (kind_e)
					K_MUL:   state_d = S_MUL;
					K_DIV:   state_d = S_DIV;
					K_LOAD:  state_d = S_LOAD;
					K_STORE: state_d = S_STORE;
					default: state_d = S_RESP;
				endcase
			end
			S_MUL:   state_d = S_RESP;
			S_DIV:   if (dcnt_q == '1) state_d = S_DIVF;
			S_DIVF:  state_d = S_RESP;
			S_LOAD:  if (cnt_q == len_q) state_d = S_RESP;
			S_STORE: if (cnt_q == len_q - 3'd1) state_d = S_RESP;
			S_RESP:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// register file and data memory port controls
	logic              rf_we, dm_we;
	logic [31:0]       rf_wd;
	logic [4:0]        ra1, ra2;
	logic [MEM_AW-1:0] dm_a;
	logic [7:0]        dm_wd;
	always_comb begin
		rf_we = 1'b0;
		rf_wd = wb_e;
		dm_we = 1'b0;
		dm_a  = addr_q + MEM_AW'(cnt_q);
		dm_wd = b[8*cnt_q[1:0] +: 8];
		ra1   = (instr_ch.instr_word[6:0] == OP_SYS) ? REG_A0 : instr_ch.instr_word[19:15];
		ra2   = (instr_ch.instr_word[6:0] == OP_SYS) ? REG_A1 : instr_ch.instr_word[24:20];
		unique case (state_q)
			S_CLEAR: begin
				dm_we = 1'b1;
				dm_a  = clr_q;
				dm_wd = '0;
			end
			S_EXEC:  rf_we = wb_en_e && kind_e == K_ALU;
			S_MUL: begin
				rf_we = 1'b1;
				rf_wd = (f3 == F3_MUL) ? prod_q[31:0] : prod_q[63:32];
			end
			S_DIVF: begin
				rf_we = 1'b1;
				rf_wd = (f3 == F3_DIV) ? q_fix : r_fix;
			end
			S_LOAD: begin
				rf_we = (cnt_q == len_q);
				rf_wd = ld_ext;
			end
			S_STORE: dm_we = 1'b1;
			default: ;
		endcase
	end

	// register file storage, x0 never written
	always_ff @(posedge clk) begin
		if (rf_we && rd != '0) rf[rd] <= rf_wd;
		if (accept) begin
			a_raw_q <= rf[ra1];
			b_raw_q <= rf[ra2];
			a_vld_q <= rf_vld_q[ra1];
			b_vld_q <= rf_vld_q[ra2];
		end
	end

	// data memory storage
	always_ff @(posedge clk) begin
		if (dm_we) dmem[dm_a] <= dm_wd;
		dm_rd_q <= dmem[dm_a];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) ir_q <= instr_ch.instr_word;
		if (accept && halted_q) begin
			res_npc_q <= pc_q;
			res_st_q  <= ST_HALTED;
			res_pv_q  <= '0;
		end
		if (state_q == S_EXEC) begin
			res_npc_q <= npc_e;
			res_st_q  <= st_e;
			res_pv_q  <= pv_e;
			prod_q    <= 66'($signed({a[31], a}) * $signed({b[31], b}));
			dq_q      <= a[31] ? -a : a;
			dd_q      <= b[31] ? -b : b;
			dr_q      <= '0;
			addr_q    <= addr_e[MEM_AW-1:0];
			len_q     <= len_e;
			ld_q      <= '0;
		end
		if (state_q == S_DIV) begin
			if (!dr_sub[32]) begin
				dr_q <= dr_sub;
				dq_q <= {dq_q[30:0], 1'b1};
			end else begin
				dr_q <= dr_sh;
				dq_q <= {dq_q[30:0], 1'b0};
			end
		end
		if (state_q == S_LOAD && cnt_q != '0) ld_q <= ld_cur;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			pc_q     <= '0;
			halted_q <= 1'b0;
			rf_vld_q <= '0;
			clr_q    <= '0;
			cnt_q    <= '0;
			dcnt_q   <= '0;
			ovalid_q <= 1'b0;
			onpc_q   <= '0;
			ost_q    <= ST_OK;
			opv_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (rf_we && rd != '0) rf_vld_q[rd] <= 1'b1;
			if (state_q == S_EXEC) begin
				cnt_q  <= '0;
				dcnt_q <= '0;
			end
			if (state_q == S_LOAD || state_q == S_STORE) cnt_q <= cnt_q + 3'd1;
			if (state_q == S_DIV) dcnt_q <= dcnt_q + 5'd1;
			if (cfg_we) pc_q <= cfg_wdata;
			if (ovalid_q && result_ch.ready) ovalid_q <= 1'b0;
			if (state_q == S_RESP && out_free) begin
				ovalid_q <= 1'b1;
				onpc_q   <= res_npc_q;
				ost_q    <= res_st_q;
				opv_q    <= res_pv_q;
				pc_q     <= res_npc_q;
				if (res_st_q != ST_OK && res_st_q != ST_PRINT) halted_q <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q) else $error("halt flag dropped");
	a_x0_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!rf_vld_q[0]) else $error("x0 written");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !instr_ch.ready) else $error("item taken during sweep");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE) else $error("item dropped");
	a_halted_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && halted_q |=> state_q == S_RESP && res_st_q == ST_HALTED)
		else $error("halted item executed");
`endif

endmodule
